### sv/keyboard_typematic_scanner_assert.svh
// Assertion macros used by the typematic scanner checker.
`ifndef KEYBOARD_TYPEMATIC_SCANNER_ASSERT_SVH
`define KEYBOARD_TYPEMATIC_SCANNER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define KTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("typematic scanner check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define KTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("typematic scanner check failed");

`endif

### sv/kts_pkg.sv
// Types and constants of the keyboard typematic scanner.
`timescale 1ns / 1ps

package kts_pkg;

	// field widths
	localparam int CODE_W    = 8;
	localparam int ELAPSED_W = 16;
	localparam int HELD_W    = 17;
	localparam int PERIOD_W  = 16;
	localparam int CNT_W     = 10;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;

	// special scancodes
	localparam logic [CODE_W-1:0] CODE_CAPS   = 8'h3A;
	localparam logic [CODE_W-1:0] CODE_LSHIFT = 8'h2A;
	localparam logic [CODE_W-1:0] CODE_RSHIFT = 8'h36;

	// repeat count wraps once it passes this
	localparam logic [CNT_W-1:0] COUNT_LIMIT = 10'd1000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAP    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REP_EN = 2'd3;

	// configuration reset values
	localparam logic [HELD_W-1:0]   DELAY_RST  = 17'd500;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd33;
	localparam logic [HELD_W-1:0]   CAP_RST    = 17'd100000;

	// per-key record kept in the record memory
	typedef struct packed {
		logic [HELD_W-1:0] held;
		logic [CNT_W-1:0]  cnt;
		logic              was_down;
	} key_rec_t;

endpackage

### sv/keyboard_typematic_scanner.sv
// Keyboard typematic scanner: per-key record memory with read-modify-write.
// Stage 1 holds a request, the output register its result. Throughput: one
// request per cycle while not stalled; the record memory has one read and one
// write port, and a record written back is forwarded to the very next read.
// Reset (arst_n low) clears control, frame and caps state, the per-entry valid
// bits (unwritten records read as zero) and returns configuration to defaults.
`timescale 1ns / 1ps

module keyboard_typematic_scanner #(
	parameter int NUM_KEYS = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [kts_pkg::CODE_W-1:0]       key_code,
	input  logic                             key_down,
	input  logic [kts_pkg::ELAPSED_W-1:0]    elapsed_ms,
	input  logic                             frame_start,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             char_valid,
	output logic [kts_pkg::CODE_W-1:0]       char_code,
	output logic                             skipped,
	output logic                             caps_lock,
	output logic                             shift_down,
	// configuration writes
	input  logic                             cfg_we,
	input  logic [kts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kts_pkg::CFG_W-1:0]        cfg_data
);

	import kts_pkg::*;

	localparam int KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int PROD_W = CNT_W + PERIOD_W;
	localparam int THR_W  = PROD_W + 1;

	// configuration registers
	logic [HELD_W-1:0]   delay_q;
	logic [PERIOD_W-1:0] period_q;
	logic [HELD_W-1:0]   cap_q;
	logic                rep_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= DELAY_RST;
			period_q <= PERIOD_RST;
			cap_q    <= CAP_RST;
			rep_en_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DELAY:  delay_q  <= cfg_data[HELD_W-1:0];
				CFG_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				CFG_CAP:    cap_q    <= cfg_data[HELD_W-1:0];
				CFG_REP_EN: rep_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake and pipeline control
	logic vld_s1, vld_s2;
	logic accept_in, s1_move;

	assign s1_move   = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall  = vld_s1 && !s1_move;
	assign accept_in = in_valid && !in_stall;

	// request held in stage 1
	logic [CODE_W-1:0]    code_s1;
	logic                 down_s1;
	logic [ELAPSED_W-1:0] elapsed_s1;
	logic                 start_s1;
	logic                 ok_s1;

	logic [KEY_W-1:0] rd_addr, wr_addr;
	logic             key_ok;

	assign rd_addr = key_code[KEY_W-1:0];
	assign wr_addr = code_s1[KEY_W-1:0];
	assign key_ok  = ({1'b0, key_code} < (CODE_W+1)'(NUM_KEYS));

	// record memory, valid bits, forwarding
	key_rec_t              rec_mem_q [NUM_KEYS];
	logic [NUM_KEYS-1:0]   ent_vld_q;
	key_rec_t              rd_rec_s1;
	key_rec_t              fwd_rec_s1;
	logic                  fwd_s1;
	logic                  ent_vld_s1;
	key_rec_t              rec_cur, rec_new;
	logic                  wr_en;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rec_mem_q[wr_addr] <= rec_new;
		end
		if (accept_in) begin
			rd_rec_s1 <= rec_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (wr_en) begin
			ent_vld_q[wr_addr] <= 1'b1;
		end
	end

	// stage 1 capture; a write at the same edge to the same key is forwarded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept_in) begin
			vld_s1 <= 1'b1;
		end else if (s1_move) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			code_s1    <= key_code;
			down_s1    <= key_down;
			elapsed_s1 <= elapsed_ms;
			start_s1   <= frame_start;
			ok_s1      <= key_ok;
			ent_vld_s1 <= key_ok && ent_vld_q[rd_addr];
			fwd_s1     <= wr_en && (wr_addr == rd_addr);
			fwd_rec_s1 <= rec_new;
		end
	end

	assign rec_cur = fwd_s1 ? fwd_rec_s1 : (ent_vld_s1 ? rd_rec_s1 : '0);

	// frame, caps and shift state
	logic frame_emitted_q, caps_q, lsh_q, rsh_q;

	// key update
	logic                frame_open, proc, emit, rep_fire, emit_now;
	logic [HELD_W:0]     held_sum;
	logic [HELD_W-1:0]   held_new;
	logic [CNT_W-1:0]    cnt_base, cnt_inc, cnt_new;
	logic [PROD_W-1:0]   prod;
	logic [THR_W-1:0]    thresh;
	logic                caps_next, lsh_next, rsh_next;

	always_comb begin
		frame_open = start_s1 || !frame_emitted_q;
		proc       = frame_open && ok_s1;

		// held time grows while down, saturating at the cap, and clears on release
		held_sum = {1'b0, rec_cur.held} + (HELD_W+1)'(elapsed_s1);
		if (!down_s1) begin
			held_new = '0;
		end else if (held_sum > {1'b0, cap_q}) begin
			held_new = cap_q;
		end else begin
			held_new = held_sum[HELD_W-1:0];
		end
		cnt_base = down_s1 ? rec_cur.cnt : '0;

		// repeat threshold: delay + count * period
		prod   = {{PERIOD_W{1'b0}}, cnt_base} * {{CNT_W{1'b0}}, period_q};
		thresh = THR_W'(delay_q) + THR_W'(prod);

		cnt_inc  = cnt_base + 1'b1;
		cnt_new  = cnt_base;
		rep_fire = 1'b0;
		if (rep_en_q && (THR_W'(held_new) > thresh)) begin
			if (cnt_inc > COUNT_LIMIT) begin
				cnt_new = '0;
			end else begin
				cnt_new  = cnt_inc;
				rep_fire = 1'b1;
			end
		end

		emit     = (down_s1 && !rec_cur.was_down) || rep_fire;
		emit_now = proc && emit;

		rec_new.held     = held_new;
		rec_new.cnt      = cnt_new;
		rec_new.was_down = emit || down_s1;

		caps_next = caps_q ^ (emit_now && (code_s1 == CODE_CAPS));
		lsh_next  = (proc && (code_s1 == CODE_LSHIFT)) ? down_s1 : lsh_q;
		rsh_next  = (proc && (code_s1 == CODE_RSHIFT)) ? down_s1 : rsh_q;
	end

	assign wr_en = s1_move && proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_emitted_q <= 1'b0;
			caps_q          <= 1'b0;
			lsh_q           <= 1'b0;
			rsh_q           <= 1'b0;
		end else if (s1_move) begin
			frame_emitted_q <= !frame_open || emit_now;
			caps_q          <= caps_next;
			lsh_q           <= lsh_next;
			rsh_q           <= rsh_next;
		end
	end

	// output register
	logic                char_valid_s2, skipped_s2, caps_s2, shift_s2;
	logic [CODE_W-1:0]   char_code_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s1_move) begin
			vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			char_valid_s2 <= emit_now;
			char_code_s2  <= emit_now ? code_s1 : '0;
			skipped_s2    <= !frame_open;
			caps_s2       <= caps_next;
			shift_s2      <= lsh_next || rsh_next;
		end
	end

	assign out_valid  = vld_s2;
	assign char_valid = char_valid_s2;
	assign char_code  = char_code_s2;
	assign skipped    = skipped_s2;
	assign caps_lock  = caps_s2;
	assign shift_down = shift_s2;

endmodule

### sv/kts_checker.sv
// Port-level checker for the keyboard typematic scanner, with its bind.
`timescale 1ns / 1ps
`include "keyboard_typematic_scanner_assert.svh"

module kts_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             char_valid,
	input logic [kts_pkg::CODE_W-1:0]       char_code,
	input logic                             skipped,
	input logic                             caps_lock,
	input logic                             shift_down
);

	import kts_pkg::*;

	// whole result payload, for stability checks
	logic [CODE_W+3:0] out_word;

	assign out_word = {char_valid, char_code, skipped, caps_lock, shift_down};

	// a stalled result stays offered and unchanged
	`KTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

	// a skipped key never emits
	`KTS_ASSERT_NOW(a_skip_no_char, out_valid && skipped, !char_valid)

	// no character means a zero code
	`KTS_ASSERT_NOW(a_idle_code_zero, out_valid && !char_valid, char_code == {CODE_W{1'b0}})

endmodule

bind keyboard_typematic_scanner kts_checker u_kts_checker (.*);
